// ===== rtl/assert_macros.svh =====
// concurrent assertion helpers, clocked on clk and quiet during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SPMQ_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPMQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/spmq_pkg.sv =====
package spmq_pkg;

  // result status codes
  localparam logic [1:0] STAT_PUSHED  = 2'd0;
  localparam logic [1:0] STAT_DROPPED = 2'd1;
  localparam logic [1:0] STAT_POPPED  = 2'd2;
  localparam logic [1:0] STAT_EMPTY   = 2'd3;

  // classified command handed from front to back
  typedef struct packed {
    logic        is_pop;
    logic [1:0]  level;
    logic [7:0]  sender;
    logic [7:0]  receiver;
    logic [15:0] content;
    logic [31:0] send_time;
  } cmd_t;

  // stored message record
  typedef struct packed {
    logic [31:0] number;
    logic [31:0] send_time;
    logic [15:0] content;
    logic [7:0]  receiver;
    logic [7:0]  sender;
  } rec_t;

  // one result word
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] number;
    logic [1:0]  level;
    logic [7:0]  sender;
    logic [7:0]  receiver;
    logic [15:0] content;
    logic [31:0] send_time;
  } res_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

endpackage

// ===== rtl/spmq_front.sv =====
`include "assert_macros.svh"

module spmq_front
  import spmq_pkg::*;
#(
  parameter int PRIORITY_LEVELS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [1:0]  in_level,
  input  logic [7:0]  in_sender,
  input  logic [7:0]  in_receiver,
  input  logic [15:0] in_content,
  input  logic [31:0] in_time,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);

  localparam logic [1:0] LVL_MAX =
    (PRIORITY_LEVELS > 4) ? 2'd3 : 2'(PRIORITY_LEVELS - 1);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       in_take;
  logic       out_take;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.is_pop    = in_action;
    // levels past the top one fold onto the top one
    cmd_in.level     = (in_level > LVL_MAX) ? LVL_MAX : in_level;
    cmd_in.sender    = in_sender;
    cmd_in.receiver  = in_receiver;
    cmd_in.content   = in_content;
    cmd_in.send_time = in_time;
  end

  assign in_ready  = (count != 2'd2);
  assign in_take   = in_valid && in_ready;
  assign cmd_valid = (count != 2'd0);
  assign out_take  = cmd_valid && cmd_ready;
  assign cmd       = q[rd_ptr];

  always_comb begin
    count_next = count;
    if (in_take && !out_take) begin
      count_next = count + 2'd1;
    end else if (!in_take && out_take) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (in_take) begin
        wr_ptr <= ~wr_ptr;
      end
      if (out_take) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  `SPMQ_ASSERT_NEXT(a_fill_up, in_take && !out_take, count == $past(count) + 2'd1, "queue count did not grow")
  `SPMQ_ASSERT_NEXT(a_fill_down, out_take && !in_take, count == $past(count) - 2'd1, "queue count did not shrink")
  `SPMQ_ASSERT(a_count_max, 1'b1, count != 2'd3, "queue count out of range")

endmodule

// ===== rtl/spmq_back.sv =====
`include "assert_macros.svh"

module spmq_back
  import spmq_pkg::*;
#(
  parameter int PRIORITY_LEVELS = 4,
  parameter int QUEUE_DEPTH     = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam int LW        = $clog2(PRIORITY_LEVELS);
  localparam int PW        = $clog2(QUEUE_DEPTH);
  localparam int CW        = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = PRIORITY_LEVELS << PW;

  rec_t          mem [MEM_DEPTH];
  rec_t          rd_data;
  rec_t          wr_rec;
  logic [PW-1:0] head [PRIORITY_LEVELS];
  logic [PW-1:0] tail [PRIORITY_LEVELS];
  logic [CW-1:0] fill [PRIORITY_LEVELS];
  logic [31:0]   number;
  logic [LW-1:0] pop_lvl;
  state_t        state;
  state_t        state_next;
  logic          out_valid;
  logic          out_valid_next;
  res_t          out_res;
  res_t          out_res_next;

  logic [LW-1:0] pick;
  logic          found;
  logic [LW-1:0] sel;
  logic [CW-1:0] cnt_sel;
  logic [PW-1:0] hd;
  logic [PW-1:0] tl;
  logic [PW-1:0] hd_adv;
  logic [PW-1:0] tl_adv;
  logic          full;
  logic          take;
  logic          wr_en;
  logic          rd_en;

  // highest non-empty level wins
  always_comb begin
    pick  = '0;
    found = 1'b0;
    for (int l = 0; l < PRIORITY_LEVELS; l++) begin
      if (fill[l] != '0) begin
        pick  = LW'(l);
        found = 1'b1;
      end
    end
  end

  assign sel     = cmd.is_pop ? pick : LW'(cmd.level);
  assign cnt_sel = fill[sel];
  assign hd      = head[sel];
  assign tl      = tail[sel];
  assign hd_adv  = (hd == PW'(QUEUE_DEPTH - 1)) ? '0 : hd + 1'b1;
  assign tl_adv  = (tl == PW'(QUEUE_DEPTH - 1)) ? '0 : tl + 1'b1;
  assign full    = (cnt_sel == CW'(QUEUE_DEPTH));

  assign take      = cmd_valid && (state == S_IDLE) && (!out_valid || res_ready);
  assign cmd_ready = take;
  assign wr_en     = take && !cmd.is_pop && !full;
  assign rd_en     = take && cmd.is_pop && found;

  always_comb begin
    wr_rec.number    = number;
    wr_rec.send_time = cmd.send_time;
    wr_rec.content   = cmd.content;
    wr_rec.receiver  = cmd.receiver;
    wr_rec.sender    = cmd.sender;
  end

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !res_ready;
    out_res_next   = out_res;
    case (state)
      S_IDLE: begin
        if (rd_en) begin
          state_next = S_READ;
        end else if (take) begin
          out_valid_next = 1'b1;
          out_res_next   = '0;
          if (cmd.is_pop) begin
            out_res_next.status = STAT_EMPTY;
          end else if (full) begin
            out_res_next.status = STAT_DROPPED;
          end else begin
            out_res_next.status = STAT_PUSHED;
            out_res_next.number = number;
          end
        end
      end
      S_READ: begin
        // output slot was drained when the pop was taken
        state_next                = S_IDLE;
        out_valid_next            = 1'b1;
        out_res_next.status       = STAT_POPPED;
        out_res_next.number       = rd_data.number;
        out_res_next.level        = 2'(pop_lvl);
        out_res_next.sender       = rd_data.sender;
        out_res_next.receiver     = rd_data.receiver;
        out_res_next.content      = rd_data.content;
        out_res_next.send_time    = rd_data.send_time;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      number    <= 32'd1;
      for (int l = 0; l < PRIORITY_LEVELS; l++) begin
        head[l] <= '0;
        tail[l] <= '0;
        fill[l] <= '0;
      end
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      if (wr_en) begin
        tail[sel] <= tl_adv;
        fill[sel] <= cnt_sel + 1'b1;
        number    <= number + 32'd1;
      end
      if (rd_en) begin
        head[sel] <= hd_adv;
        fill[sel] <= cnt_sel - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_res <= out_res_next;
    if (rd_en) begin
      pop_lvl <= sel;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{sel, tl}] <= wr_rec;
    end
    if (rd_en) begin
      rd_data <= mem[{sel, hd}];
    end
  end

  assign res_valid = out_valid;
  assign res       = out_res;

  `SPMQ_ASSERT(a_read_slot_free, state == S_READ, !out_valid, "pop data arrives on a busy output")
  `SPMQ_ASSERT_NEXT(a_read_done, state == S_READ, state == S_IDLE && out_valid, "pop result not posted")
  `SPMQ_ASSERT_NEXT(a_num_step, wr_en, number == $past(number) + 32'd1, "message number did not advance")
  `SPMQ_ASSERT_NEXT(a_drop_holds, take && !cmd.is_pop && full, number == $past(number), "dropped push moved the number")

endmodule

// ===== rtl/strict_priority_message_queue_top.sv =====
// strict priority message queue
// s_axis carries commands: tuser selects push (0) or pop (1); a push word holds
// level, sender, receiver, content handle and send time. m_axis returns one word
// per command: tuser is the status (pushed, dropped because full, popped, empty),
// tdata carries the message number and, for a pop, the stored record.
// every push gets a running message number starting at 1 that wraps at 2^32;
// a dropped push does not use a number.
// commands pass through a two-entry queue into the execution unit, which owns
// the per-level pointers, fill counts and the record memory.
// results are registered: a push result is posted when the execution unit takes
// the push; a pop also passes through the read state for the registered read of
// the record memory, and no command is taken until that pop result is posted.
// reset empties every level and sets the number counter to 1; the record memory
// itself is not cleared. while m_axis_tready is low the result stays on m_axis
// and the command queue fills, then s_axis_tready drops.
module strict_priority_message_queue_top
  import spmq_pkg::*;
#(
  parameter int PRIORITY_LEVELS = 4,
  parameter int QUEUE_DEPTH     = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // level, sender_id, receiver_id, content_handle, send_time, zero pad
  input  logic [71:0]  s_axis_tdata,
  // action
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // message_number, out_level, out_sender, out_receiver, out_content, out_time,
  // zero pad
  output logic [103:0] m_axis_tdata,
  // status
  output logic [1:0]   m_axis_tuser
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  res_t res;

  spmq_front #(
    .PRIORITY_LEVELS(PRIORITY_LEVELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_action  (s_axis_tuser),
    .in_level   (s_axis_tdata[1:0]),
    .in_sender  (s_axis_tdata[9:2]),
    .in_receiver(s_axis_tdata[17:10]),
    .in_content (s_axis_tdata[33:18]),
    .in_time    (s_axis_tdata[65:34]),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  spmq_back #(
    .PRIORITY_LEVELS(PRIORITY_LEVELS),
    .QUEUE_DEPTH    (QUEUE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .res_valid(m_axis_tvalid),
    .res_ready(m_axis_tready),
    .res      (res)
  );

  assign m_axis_tuser = res.status;
  assign m_axis_tdata = {6'd0, res.send_time, res.content, res.receiver, res.sender,
                         res.level, res.number};

endmodule

// ===== dv/tb_strict_priority_message_queue_top.sv =====
module tb_strict_priority_message_queue_top
  import spmq_pkg::*;
();

  localparam int LEVELS = 4;
  localparam int DEPTH  = 16;

  logic         clk;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // level, sender_id, receiver_id, content_handle, send_time, zero pad
  logic [71:0]  s_axis_tdata = '0;
  // action
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // message_number, out_level, out_sender, out_receiver, out_content, out_time,
  // zero pad
  logic [103:0] m_axis_tdata;
  // status
  logic [1:0]   m_axis_tuser;

  strict_priority_message_queue_top #(
    .PRIORITY_LEVELS(LEVELS),
    .QUEUE_DEPTH    (DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // commands waiting to be offered, and results the queue still owes
  cmd_t cmd_backlog[$];
  res_t due_results[$];

  // shadow of the per-level fifos and the number counter
  rec_t        level_store [LEVELS][DEPTH];
  int unsigned rd_idx [LEVELS];
  int unsigned wr_idx [LEVELS];
  int unsigned occupancy [LEVELS];
  logic [31:0] number_ctr;

  int   errors = 0;
  int   in_count = 0;
  logic in_fire = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb_strict_priority_message_queue_top NOT OK");
    $finish;
  end

  function automatic void clear_shadow();
    for (int l = 0; l < LEVELS; l++) begin
      rd_idx[l] = 0;
      wr_idx[l] = 0;
      occupancy[l] = 0;
    end
    number_ctr = 32'd1;
  endfunction

  function automatic void add_cmd(cmd_t c);
    cmd_backlog.insert(cmd_backlog.size(), c);
  endfunction

  // one command in, one expected result word out
  function automatic void apply_command(cmd_t c);
    res_t r;
    int   lv;
    r  = '0;
    lv = int'(c.level);
    if (lv >= LEVELS) lv = LEVELS - 1;
    if (!c.is_pop) begin
      if (occupancy[lv] >= DEPTH) begin
        r.status = STAT_DROPPED;
      end else begin
        level_store[lv][wr_idx[lv]] = '{number: number_ctr, send_time: c.send_time,
                                        content: c.content, receiver: c.receiver,
                                        sender: c.sender};
        wr_idx[lv] = (wr_idx[lv] + 1) % DEPTH;
        occupancy[lv]++;
        r.status = STAT_PUSHED;
        r.number = number_ctr;
        number_ctr = number_ctr + 32'd1;
      end
    end else begin
      r.status = STAT_EMPTY;
      for (int l = LEVELS - 1; l >= 0; l--) begin
        if (occupancy[l] != 0 && r.status == STAT_EMPTY) begin
          rec_t rec;
          rec = level_store[l][rd_idx[l]];
          r.status    = STAT_POPPED;
          r.number    = rec.number;
          r.level     = 2'(l);
          r.sender    = rec.sender;
          r.receiver  = rec.receiver;
          r.content   = rec.content;
          r.send_time = rec.send_time;
          rd_idx[l] = (rd_idx[l] + 1) % DEPTH;
          occupancy[l]--;
        end
      end
    end
    due_results.insert(due_results.size(), r);
  endfunction

  function automatic cmd_t rand_cmd(logic pop, logic [1:0] lvl);
    cmd_t c;
    c.is_pop    = pop;
    c.level     = lvl;
    c.sender    = 8'($urandom());
    c.receiver  = 8'($urandom());
    c.content   = 16'($urandom());
    c.send_time = $urandom();
    // lean on the extremes now and then
    case ($urandom_range(0, 9))
      0: begin c.sender = '1; c.receiver = '0; c.content = '1; c.send_time = '0; end
      1: begin c.sender = '0; c.receiver = '1; c.content = '0; c.send_time = '1; end
      default: ;
    endcase
    return c;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  // monitor: capture accepted commands and check result words
  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        cmd_t c;
        c.is_pop    = s_axis_tuser;
        c.level     = s_axis_tdata[1:0];
        c.sender    = s_axis_tdata[9:2];
        c.receiver  = s_axis_tdata[17:10];
        c.content   = s_axis_tdata[33:18];
        c.send_time = s_axis_tdata[65:34];
        apply_command(c);
        in_count++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_results.size() == 0) begin
          $error("result word with nothing outstanding: status %h", m_axis_tuser);
          errors++;
        end else begin
          res_t want;
          want = due_results.pop_front();
          check_field("status", 32'(want.status), 32'(m_axis_tuser));
          check_field("message_number", want.number, m_axis_tdata[31:0]);
          check_field("out_level", 32'(want.level), 32'(m_axis_tdata[33:32]));
          check_field("out_sender", 32'(want.sender), 32'(m_axis_tdata[41:34]));
          check_field("out_receiver", 32'(want.receiver), 32'(m_axis_tdata[49:42]));
          check_field("out_content", 32'(want.content), 32'(m_axis_tdata[65:50]));
          check_field("out_time", want.send_time, m_axis_tdata[97:66]);
        end
      end
    end
  end

  // driver: bursts of words with random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin
    if (!rst && !(s_axis_tvalid && !in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        cmd_t c;
        c = cmd_backlog.pop_front();
        s_axis_tdata  <= {6'b0, c.send_time, c.content, c.receiver, c.sender, c.level};
        s_axis_tuser  <= c.is_pop;
        s_axis_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left--;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: changing stall pattern plus one long hold-off to back up the input
  int   rx_cycle = 0;
  int   rx_mode = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;

  always @(negedge clk) begin
    logic rdy;
    rx_cycle++;
    if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (!hold_done && in_count >= 300) begin
      hold_left = 150;
      hold_done = 1'b1;
      rdy = 1'b0;
    end else begin
      case (rx_mode)
        0: rdy = 1'b1;
        1: rdy = 1'($urandom_range(0, 1));
        2: rdy = ($urandom_range(0, 3) == 0);
        default: rdy = (rx_cycle % 5) < 3;
      endcase
    end
    m_axis_tready <= rdy;
  end

  initial begin
    int n;
    int style;
    int len;
    int focus;
    logic pop;
    logic [1:0] lvl;

    clear_shadow();

    // directed: empty pop, field extremes, priority order, overflow of one level
    add_cmd('{is_pop: 1'b1, default: '0});
    add_cmd('{is_pop: 1'b0, level: 2'd0, default: '0});
    add_cmd('{is_pop: 1'b0, level: 2'd3, sender: '1, receiver: '1,
              content: '1, send_time: '1});
    add_cmd(rand_cmd(1'b0, 2'd1));
    add_cmd(rand_cmd(1'b0, 2'd2));
    for (int k = 0; k < 5; k++) add_cmd(rand_cmd(1'b1, 2'd0));
    for (int k = 0; k < DEPTH + 1; k++) add_cmd(rand_cmd(1'b0, 2'd3));

    // random: runs biased toward filling, draining, or mixing
    n = 0;
    while (n < 900) begin
      style = $urandom_range(0, 3);
      len   = $urandom_range(8, 60);
      focus = $urandom_range(0, 3);
      for (int k = 0; k < len; k++) begin
        case (style)
          0: pop = ($urandom_range(0, 9) == 0);
          1: pop = ($urandom_range(0, 19) < 17);
          default: pop = 1'($urandom_range(0, 1));
        endcase
        lvl = (style == 0 && $urandom_range(0, 3) != 0) ? 2'(focus) : 2'($urandom_range(0, 3));
        add_cmd(rand_cmd(pop, lvl));
      end
      n += len;
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (errors == 0) begin
      $display("tb_strict_priority_message_queue_top OK");
    end else begin
      $display("tb_strict_priority_message_queue_top NOT OK");
    end
    $finish;
  end

endmodule
